@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the tower field multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// Whenever ante holds at a clock edge, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

@@ rtl/core/btfm_pkg.sv @@
// Package with constants and tower field helper functions for the multiplier.
`timescale 1ns / 1ps

package btfm_pkg;

  // Default and largest supported tower depth (GF(2^128)).
  localparam int unsigned TowerLevelsDef = 7;
  localparam int unsigned TowerLevelsMax = 7;

  // Width of one full field element, carried on two 64-bit ports.
  localparam int unsigned FieldBitsMax = 128;

  function automatic logic [63:0] low_mask(int unsigned w);
    logic [63:0] m;
    if (w >= 64) begin
      m = '1;
    end else begin
      m = (64'd1 << w) - 64'd1;
    end
    return m;
  endfunction

  // Multiplies x by alpha in the tower field of 2^lvl bits (lvl at most 6).
  // Built bottom up along the chain of high halves of x.
  function automatic logic [63:0] times_alpha(logic [63:0] x, int unsigned lvl);
    logic [63:0] r;
    logic [63:0] xs;
    int unsigned w;
    int unsigned ws;
    int unsigned hs;
    w = 1 << lvl;
    r = (x >> (w - 1)) & 64'd1;
    for (int unsigned s = 1; s <= lvl; s++) begin
      ws = 1 << s;
      hs = ws >> 1;
      xs = (x >> (w - ws)) & low_mask(ws);
      r = ((xs >> hs) & low_mask(hs)) | ((((xs & low_mask(hs)) ^ r) & low_mask(hs)) << hs);
    end
    if (lvl == 0) begin
      r = x & 64'd1;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/binary_tower_field_multiplier.sv @@
// Pipelined Karatsuba multiplier for binary tower fields, one product per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Multiplies two elements of the binary tower field of 2^TOWER_LEVELS bits
// (GF(2^128) by default). A new operand pair is taken in every cycle and busy
// stays low, so start may be held high continuously. Each product appears
// in order, with result_valid_o high for exactly one cycle; the receiver must
// take it then, since the pipeline has no way to hold results back. In the
// stage structure, one register stage per tower level splits the
// operands into Karatsuba sub-operands, one stage forms the one-bit products,
// and one stage per tower level recombines them. With fewer than seven levels
// only the low bits of a_low_i and b_low_i are used and the unused product bits
// are zero.
module binary_tower_field_multiplier
  import btfm_pkg::*;
#(
  parameter int unsigned TOWER_LEVELS = TowerLevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] a_low_i,
  input  logic [63:0] a_high_i,
  input  logic [63:0] b_low_i,
  input  logic [63:0] b_high_i,
  output logic        result_valid_o,
  output logic [63:0] product_low_o,
  output logic [63:0] product_high_o
);

  localparam int unsigned Lvl     = (TOWER_LEVELS > TowerLevelsMax) ? TowerLevelsMax
                                                                    : TOWER_LEVELS;
  localparam int unsigned OpW     = 1 << Lvl;
  localparam int unsigned TotBits = 3 ** Lvl;
  localparam int unsigned Lat     = 2 * Lvl + 1;

  // Splits every item of level lvl into its low half, high half and their sum.
  function automatic logic [TotBits-1:0] expand_level(logic [TotBits-1:0] src,
                                                      int unsigned lvl);
    logic [TotBits-1:0] dst;
    logic               lo;
    logic               hi;
    int unsigned        n;
    int unsigned        w;
    int unsigned        h;
    n = 1;
    for (int unsigned t = lvl; t < Lvl; t++) begin
      n = n * 3;
    end
    w = 1 << lvl;
    h = w >> 1;
    dst = '0;
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned b = 0; b < h; b++) begin
        lo = src[i * w + b];
        hi = src[i * w + h + b];
        dst[3 * i * h + b]       = lo;
        dst[(3 * i + 1) * h + b] = hi;
        dst[(3 * i + 2) * h + b] = lo ^ hi;
      end
    end
    return dst;
  endfunction

  // Recombines three sub-products of level lvl-1 into each product of level lvl.
  function automatic logic [TotBits-1:0] combine_level(logic [TotBits-1:0] src,
                                                       int unsigned lvl);
    logic [TotBits-1:0] dst;
    logic [63:0]        z0;
    logic [63:0]        z1;
    logic [63:0]        z2;
    logic [63:0]        lo;
    logic [63:0]        hi;
    int unsigned        n;
    int unsigned        h;
    n = 1;
    for (int unsigned t = lvl; t < Lvl; t++) begin
      n = n * 3;
    end
    h = 1 << (lvl - 1);
    dst = '0;
    for (int unsigned i = 0; i < n; i++) begin
      z0 = '0;
      z1 = '0;
      z2 = '0;
      for (int unsigned b = 0; b < h; b++) begin
        z0[b] = src[3 * i * h + b];
        z2[b] = src[(3 * i + 1) * h + b];
        z1[b] = src[(3 * i + 2) * h + b];
      end
      lo = z0 ^ z2;
      hi = z1 ^ z0 ^ z2 ^ times_alpha(z2, lvl - 1);
      for (int unsigned b = 0; b < h; b++) begin
        dst[2 * i * h + b]     = lo[b];
        dst[2 * i * h + h + b] = hi[b];
      end
    end
    return dst;
  endfunction

  logic                accept;
  logic [TotBits-1:0]  op_a;
  logic [TotBits-1:0]  op_b;
  logic [FieldBitsMax-1:0] prod_full;
  logic                a_is_zero;
  logic                prod_is_zero;

  logic [TotBits-1:0]  ea_d [1:Lvl];
  logic [TotBits-1:0]  ea_q [1:Lvl];
  logic [TotBits-1:0]  eb_d [1:Lvl];
  logic [TotBits-1:0]  eb_q [1:Lvl];
  logic [TotBits-1:0]  p_d  [0:Lvl];
  logic [TotBits-1:0]  p_q  [0:Lvl];
  logic [Lat-1:0]      vld_d;
  logic [Lat-1:0]      vld_q;

  // Every stage advances each cycle, so a transfer is never refused.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  if (OpW >= FieldBitsMax) begin : g_full
    assign op_a      = {{(TotBits - FieldBitsMax){1'b0}}, a_high_i, a_low_i};
    assign op_b      = {{(TotBits - FieldBitsMax){1'b0}}, b_high_i, b_low_i};
    assign prod_full = p_q[Lvl][FieldBitsMax-1:0];
  end else begin : g_small
    assign op_a      = {{(TotBits - OpW){1'b0}}, a_low_i[OpW-1:0]};
    assign op_b      = {{(TotBits - OpW){1'b0}}, b_low_i[OpW-1:0]};
    assign prod_full = {{(FieldBitsMax - OpW){1'b0}}, p_q[Lvl][OpW-1:0]};
  end

  always_comb begin
    ea_d[Lvl] = op_a;
    eb_d[Lvl] = op_b;
    for (int unsigned j = Lvl; j >= 2; j--) begin
      ea_d[j-1] = expand_level(ea_q[j], j);
      eb_d[j-1] = expand_level(eb_q[j], j);
    end
    // The last split yields single bits, whose product is a plain AND.
    p_d[0] = expand_level(ea_q[1], 1) & expand_level(eb_q[1], 1);
    for (int unsigned j = 1; j <= Lvl; j++) begin
      p_d[j] = combine_level(p_q[j-1], j);
    end
    vld_d = {vld_q[Lat-2:0], accept};
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned j = 1; j <= Lvl; j++) begin
      ea_q[j] <= ea_d[j];
      eb_q[j] <= eb_d[j];
    end
    for (int unsigned j = 0; j <= Lvl; j++) begin
      p_q[j] <= p_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign result_valid_o = vld_q[Lat-1];
  assign product_low_o  = prod_full[63:0];
  assign product_high_o = prod_full[127:64];

  assign a_is_zero    = (a_low_i == '0) && (a_high_i == '0);
  assign prod_is_zero = (product_low_o == '0) && (product_high_o == '0);

  // A result only leaves the pipeline for a transfer whose flag has passed the whole valid chain.
  `ASSERT_IMPLIES(a_result_has_transfer, clk_i, rst_ni, result_valid_o, $past(accept, Lat))
  // A zero first operand must give a zero product.
  `ASSERT_IMPLIES(a_zero_operand, clk_i, rst_ni, result_valid_o && $past(a_is_zero, Lat), prod_is_zero)
  // Small towers never drive the upper product word.
  `ASSERT_IMPLIES(a_small_high_zero, clk_i, rst_ni, result_valid_o && (OpW < FieldBitsMax), product_high_o == '0)
  // The valid chain only moves one stage per cycle.
  `ASSERT_NEXT(a_valid_shift, clk_i, rst_ni, vld_q[0], vld_q[1])

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the pipelined binary tower field multiplier.
`timescale 1ns / 1ps

module tb_top;
  import btfm_pkg::*;

  localparam int unsigned LEVELS = TowerLevelsDef;
  localparam int unsigned FIELD_LEVELS = (LEVELS > TowerLevelsMax) ? TowerLevelsMax : LEVELS;
  localparam int unsigned PIPE_DEPTH = 2 * LEVELS + 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } product_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] a_low_i;
  logic [63:0] a_high_i;
  logic [63:0] b_low_i;
  logic [63:0] b_high_i;
  logic        result_valid_o;
  logic [63:0] product_low_o;
  logic [63:0] product_high_o;

  product_t    pending_products[$];
  product_t    due_product;
  int unsigned xfer_count = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  binary_tower_field_multiplier #(
    .TOWER_LEVELS(LEVELS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .a_low_i       (a_low_i),
    .a_high_i      (a_high_i),
    .b_low_i       (b_low_i),
    .b_high_i      (b_high_i),
    .result_valid_o(result_valid_o),
    .product_low_o (product_low_o),
    .product_high_o(product_high_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bits whose index has bit j clear: the low half of every block of 2^(j+1) bits.
  function automatic logic [127:0] low_halves(int unsigned j);
    case (j)
      0:       return {32{4'h5}};
      1:       return {32{4'h3}};
      2:       return {16{8'h0F}};
      3:       return {8{16'h00FF}};
      4:       return {4{32'h0000_FFFF}};
      5:       return {2{64'h0000_0000_FFFF_FFFF}};
      default: return {64'd0, ALL_ONES};
    endcase
  endfunction

  // Multiplies every 2^(k+1)-bit block of x by the generator X_k of that block's
  // field. X_k * (lo + hi X_k) = hi + (lo + X_(k-1) hi) X_k, with X_(-1) = 1, so
  // the halves are peeled top down and the products rebuilt bottom up.
  function automatic logic [127:0] times_generator(logic [127:0] x, int k);
    logic [127:0] lows[0:7];
    logic [127:0] highs[0:7];
    logic [127:0] cur;
    logic [127:0] acc;
    cur = x;
    for (int j = k; j >= 0; j--) begin
      lows[j]  = cur & low_halves(j);
      highs[j] = (cur >> (1 << j)) & low_halves(j);
      cur = highs[j];
    end
    acc = highs[0];
    for (int j = 0; j <= k; j++) begin
      acc = highs[j] ^ ((lows[j] ^ acc) << (1 << j));
    end
    return acc;
  endfunction

  // Product in the tower field, expanded over the monomial basis of b: bit j of
  // an element is the coefficient of the product of X_k over the set bits k of j.
  function automatic product_t tower_product(logic [63:0] al, logic [63:0] ah,
                                             logic [63:0] bl, logic [63:0] bh);
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] term;
    logic [127:0] acc;
    product_t     res;
    int unsigned  nbits;
    nbits = 1 << FIELD_LEVELS;
    a = {ah, al};
    b = {bh, bl};
    if (FIELD_LEVELS < 7) begin
      a = {64'd0, al & ((64'd1 << nbits) - 64'd1)};
      b = {64'd0, bl & ((64'd1 << nbits) - 64'd1)};
    end
    acc = '0;
    for (int j = 0; j < nbits; j++) begin
      if (b[j]) begin
        term = a;
        for (int k = 0; k < FIELD_LEVELS; k++) begin
          if (((j >> k) & 1) != 0) term = times_generator(term, k);
        end
        acc ^= term;
      end
    end
    res.lo = acc[63:0];
    res.hi = acc[127:64];
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Result checking and transfer capture, both on the rising edge.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_products.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected product %h_%h", $realtime, product_high_o, product_low_o);
          end
        end else begin
          due_product = pending_products.pop_front();
          if (product_low_o !== due_product.lo) begin
            note_mismatch("product_low", due_product.lo, product_low_o);
          end
          if (product_high_o !== due_product.hi) begin
            note_mismatch("product_high", due_product.hi, product_high_o);
          end
        end
      end
      if (start && !busy) begin
        pending_products.push_back(tower_product(a_low_i, a_high_i, b_low_i, b_high_i));
        xfer_count <= xfer_count + 1;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Words with structure: zero, all ones, single bits, sparse or dense patterns.
  function automatic logic [63:0] shaped_word();
    case ($urandom_range(0, 5))
      0:       return 64'd0;
      1:       return ALL_ONES;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return rand_word() & rand_word() & rand_word();
      4:       return rand_word() | rand_word();
      default: return rand_word();
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_operands(logic [63:0] al, logic [63:0] ah,
                               logic [63:0] bl, logic [63:0] bh);
    int unsigned seen;
    a_low_i  = al;
    a_high_i = ah;
    b_low_i  = bl;
    b_high_i = bh;
    start    = 1'b1;
    seen = xfer_count;
    do @(negedge clk_i); while (xfer_count == seen);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) begin
      start    = 1'b0;
      a_low_i  = rand_word();
      a_high_i = rand_word();
      b_low_i  = rand_word();
      b_high_i = rand_word();
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  task automatic random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      idle_cycles(0);
    end else if (r < 90) begin
      idle_cycles($urandom_range(1, 3));
    end else begin
      idle_cycles($urandom_range(8, 40));
    end
  endtask

  task automatic directed_pair(logic [63:0] al, logic [63:0] ah,
                               logic [63:0] bl, logic [63:0] bh);
    send_operands(al, ah, bl, bh);
    random_gap();
  endtask

  task automatic test_directed_operands();
    logic [63:0] r0;
    logic [63:0] r1;
    r0 = rand_word();
    r1 = rand_word();
    directed_pair(64'd0, 64'd0, 64'd0, 64'd0);
    directed_pair(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    directed_pair(64'd1, 64'd0, r0, r1);
    directed_pair(r1, r0, 64'd1, 64'd0);
    directed_pair(64'd0, 64'd0, r0, r1);
    directed_pair(64'd0, 64'd1, 64'd0, 64'd1);
    directed_pair(64'd2, 64'd0, 64'd2, 64'd0);
    directed_pair(64'h1_0000_0000, 64'd0, 64'h1_0000_0000, 64'd0);
    directed_pair(ALL_ONES, 64'd0, ALL_ONES, 64'd0);
    directed_pair(64'd0, ALL_ONES, 64'd0, ALL_ONES);
    directed_pair({16{4'h5}}, {16{4'hA}}, {16{4'hA}}, {16{4'h5}});
    directed_pair(64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000, 64'd0);
    directed_pair(64'd0, 64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000);
    directed_pair(ALL_ONES, ALL_ONES, 64'd1, 64'd0);
    directed_pair(64'd0, 64'h8000_0000_0000_0000, ALL_ONES, ALL_ONES);
    directed_pair(r0, r1, r0, r1);
    directed_pair(ALL_ONES, ALL_ONES, 64'd0, 64'd0);
  endtask

  task automatic test_random_operands(int unsigned count);
    repeat (count) begin
      send_operands(rand_word(), rand_word(), rand_word(), rand_word());
      random_gap();
    end
  endtask

  task automatic test_shaped_operands(int unsigned count);
    repeat (count) begin
      send_operands(shaped_word(), shaped_word(), shaped_word(), shaped_word());
      random_gap();
    end
  endtask

  // A long stretch with a new transfer on every clock.
  task automatic test_back_to_back(int unsigned count);
    repeat (count) begin
      send_operands(rand_word(), rand_word(), rand_word(), rand_word());
    end
    random_gap();
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    a_low_i  = '0;
    a_high_i = '0;
    b_low_i  = '0;
    b_high_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed_operands();
    test_random_operands(400);
    test_back_to_back(150);
    test_shaped_operands(300);
    test_back_to_back(60);
    test_random_operands(130);
    start = 1'b0;

    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
    if (pending_products.size() != 0) begin
      fail_count += pending_products.size();
      $display("%0d products never arrived", pending_products.size());
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
